// ===== hdl/shamir_share_combine_top_defines.svh =====
// Assertion macros used by the checks in the top level of this block
`ifndef SHAMIR_SHARE_COMBINE_TOP_DEFINES_SVH
`define SHAMIR_SHARE_COMBINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define SSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssc check failed");

// Next-cycle implication, clocked on clk, off during reset
`define SSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssc check failed");

`endif

// ===== hdl/ssc_pkg.sv =====
`timescale 1ns / 1ps
package ssc_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int SHARE_BYTES_DEF = 32;
    localparam int ROW_BITS        = 5;      // share store row is always 32 bytes
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [8:0] GF_ORDER = 9'h0FF;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef logic [7:0] gf_tab_t [256];

    // Command bits from controller to datapath
    typedef struct packed {
        logic x_we;
        logic s_we;
        logic acc_clr;
        logic acc_en;
        logic acc_self;
        logic latch_xi;
        logic latch_w;
        logic mix_en;
        logic emit_load;
        logic emit_last;
        logic clear;
    } ssc_cmd_t;

    // Status bits from datapath to controller
    typedef struct packed {
        logic xi_zero;
        logic out_busy;
    } ssc_sts_t;

    function automatic gf_tab_t gf_exp_build();
        gf_tab_t    t;
        logic [8:0] v;
        t = '{default: 8'h00};
        v = 9'h001;
        for (int k = 0; k < 255; k++)
        begin
            t[k] = v[7:0];
            v = {v[7:0], 1'b0};
            if (v[8])
            begin
                v = v ^ GF_POLY;
            end
        end
        t[255] = t[0];
        return t;
    endfunction

    function automatic gf_tab_t gf_log_build();
        gf_tab_t    t;
        logic [8:0] v;
        t = '{default: 8'h00};
        v = 9'h001;
        for (int k = 0; k < 255; k++)
        begin
            t[v[7:0]] = 8'(k);
            v = {v[7:0], 1'b0};
            if (v[8])
            begin
                v = v ^ GF_POLY;
            end
        end
        return t;
    endfunction

    localparam gf_tab_t GF_EXP = gf_exp_build();
    localparam gf_tab_t GF_LOG = gf_log_build();

endpackage

// ===== hdl/ssc_ram.sv =====
`timescale 1ns / 1ps
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ssc_datapath.sv =====
`timescale 1ns / 1ps
module ssc_datapath #(
    parameter int SLOTS       = ssc_pkg::SLOTS_DEF,
    parameter int SHARE_BYTES = ssc_pkg::SHARE_BYTES_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int PW = (SHARE_BYTES > 1) ? $clog2(SHARE_BYTES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssc_pkg::ssc_cmd_t             cmd,
    output ssc_pkg::ssc_sts_t             sts,
    input  logic [7:0]                    in_slot,
    input  logic [7:0]                    in_x,
    input  logic [4:0]                    in_pos,
    input  logic [7:0]                    in_byte,
    input  logic [SW-1:0]                 x_raddr,
    input  logic [SW+ssc_pkg::ROW_BITS-1:0] s_raddr,
    input  logic [PW-1:0]                 mix_pos,
    input  logic [PW-1:0]                 emit_pos,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic [4:0]                    out_position,
    output logic                          out_last
);

    logic [SLOTS-1:0] xvalid_reg;
    logic             xv_rd_reg;
    logic [7:0]       x_rdata;
    logic [7:0]       s_rdata;
    logic [7:0]       xval;
    logic [7:0]       xi_reg;
    logic [7:0]       top_reg, top_next;
    logic [7:0]       bot_reg, bot_next;
    logic [7:0]       w_reg, w_next;
    logic [8:0]       top_sum, bot_sum, w_sum, e_sum;
    logic [7:0]       e_idx;
    logic [7:0]       term;
    logic [7:0]       secret_reg [SHARE_BYTES];
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [4:0]       out_pos_reg;
    logic             out_last_reg;

    // x coordinate table, valid bits give the zero reset
    ssc_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_xram (
        .clk   (clk),
        .we    (cmd.x_we),
        .waddr (in_slot[SW-1:0]),
        .wdata (in_x),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    // share bytes, row of 32 per slot
    ssc_ram #(.WIDTH(8), .DEPTH(SLOTS << ssc_pkg::ROW_BITS)) u_sram (
        .clk   (clk),
        .we    (cmd.s_we),
        .waddr ({in_slot[SW-1:0], in_pos}),
        .wdata (in_byte),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xvalid_reg <= '0;
            xv_rd_reg  <= 1'b0;
        end
        else
        begin
            xv_rd_reg <= xvalid_reg[x_raddr];
            if (cmd.clear)
            begin
                xvalid_reg <= '0;
            end
            else if (cmd.x_we)
            begin
                xvalid_reg[in_slot[SW-1:0]] <= 1'b1;
            end
        end
    end

    assign xval = xv_rd_reg ? x_rdata : 8'h00;
    assign sts.xi_zero = (xval == 8'h00);

    // log-domain accumulation mod 255
    always_comb
    begin
        top_sum  = {1'b0, top_reg} + {1'b0, ssc_pkg::GF_LOG[xval]};
        bot_sum  = {1'b0, bot_reg} + {1'b0, ssc_pkg::GF_LOG[xi_reg ^ xval]};
        top_next = (top_sum >= ssc_pkg::GF_ORDER) ? 8'(top_sum - ssc_pkg::GF_ORDER)
                                                  : top_sum[7:0];
        bot_next = (bot_sum >= ssc_pkg::GF_ORDER) ? 8'(bot_sum - ssc_pkg::GF_ORDER)
                                                  : bot_sum[7:0];
        w_sum    = (top_reg >= bot_reg) ? ({1'b0, top_reg} - {1'b0, bot_reg})
                                        : ({1'b0, top_reg} + ssc_pkg::GF_ORDER
                                           - {1'b0, bot_reg});
        w_next   = w_sum[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_xi)
        begin
            xi_reg <= xval;
        end
        if (cmd.acc_clr)
        begin
            top_reg <= 8'h00;
            bot_reg <= 8'h00;
        end
        else if (cmd.acc_en && !cmd.acc_self && xval != 8'h00)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
        if (cmd.latch_w)
        begin
            w_reg <= w_next;
        end
    end

    // weight times share byte, through log and exp
    always_comb
    begin
        e_sum = {1'b0, w_reg} + {1'b0, ssc_pkg::GF_LOG[s_rdata]};
        e_idx = (e_sum >= ssc_pkg::GF_ORDER) ? 8'(e_sum - ssc_pkg::GF_ORDER) : e_sum[7:0];
        term  = ssc_pkg::GF_EXP[e_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SHARE_BYTES; k++)
            begin
                secret_reg[k] <= 8'h00;
            end
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < SHARE_BYTES; k++)
            begin
                secret_reg[k] <= 8'h00;
            end
        end
        else if (cmd.mix_en && s_rdata != 8'h00)
        begin
            secret_reg[mix_pos] <= secret_reg[mix_pos] ^ term;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_byte_reg <= secret_reg[emit_pos];
            out_pos_reg  <= 5'(emit_pos);
            out_last_reg <= cmd.emit_last;
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_position = out_pos_reg;
    assign out_last     = out_last_reg;

endmodule

// ===== hdl/ssc_ctrl.sv =====
`timescale 1ns / 1ps
module ssc_ctrl #(
    parameter int SLOTS       = ssc_pkg::SLOTS_DEF,
    parameter int SHARE_BYTES = ssc_pkg::SHARE_BYTES_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int PW = (SHARE_BYTES > 1) ? $clog2(SHARE_BYTES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [7:0]                    in_slot,
    input  logic [4:0]                    in_pos,
    output logic [SW-1:0]                 x_raddr,
    output logic [SW+ssc_pkg::ROW_BITS-1:0] s_raddr,
    output logic [PW-1:0]                 mix_pos,
    output logic [PW-1:0]                 emit_pos,
    output ssc_pkg::ssc_cmd_t             cmd,
    input  ssc_pkg::ssc_sts_t             sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IREAD = 4'd1;
    localparam logic [3:0] S_ICHK  = 4'd2;
    localparam logic [3:0] S_JRUN  = 4'd3;
    localparam logic [3:0] S_JEND  = 4'd4;
    localparam logic [3:0] S_WGT   = 4'd5;
    localparam logic [3:0] S_PRUN  = 4'd6;
    localparam logic [3:0] S_PEND  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [SW-1:0] I_LAST = SW'(SLOTS - 1);
    localparam logic [PW-1:0] P_LAST = PW'(SHARE_BYTES - 1);

    logic [3:0]    state_reg, state_next;
    logic [SW-1:0] i_reg, i_next;
    logic [SW-1:0] j_reg, j_next;
    logic [PW-1:0] p_reg, p_next;
    logic          acc_en_reg, acc_en_next;
    logic          self_reg, self_next;
    logic          mix_en_reg, mix_en_next;
    logic [PW-1:0] mix_pos_reg, mix_pos_next;
    logic          accept;
    logic          in_range;

    // ready is high exactly in idle
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_range = ({1'b0, in_slot} < 9'(SLOTS)) && ({1'b0, in_pos} < 6'(SHARE_BYTES));

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        acc_en_next  = 1'b0;
        self_next    = 1'b0;
        mix_en_next  = 1'b0;
        mix_pos_next = mix_pos_reg;
        in_ready     = 1'b0;
        x_raddr      = i_reg;
        cmd          = '0;
        cmd.acc_en   = acc_en_reg;
        cmd.acc_self = self_reg;
        cmd.mix_en   = mix_en_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && in_kind == ssc_pkg::KIND_LOAD && in_range)
                begin
                    cmd.x_we = 1'b1;
                    cmd.s_we = 1'b1;
                end
                else if (accept && in_kind == ssc_pkg::KIND_EXTRACT)
                begin
                    i_next     = '0;
                    state_next = S_IREAD;
                end
            end
            S_IREAD:
            begin
                state_next = S_ICHK;
            end
            S_ICHK:
            begin
                if (sts.xi_zero)
                begin
                    if (i_reg == I_LAST)
                    begin
                        p_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_IREAD;
                    end
                end
                else
                begin
                    cmd.latch_xi = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    j_next       = '0;
                    state_next   = S_JRUN;
                end
            end
            // walk all slots for the other x values
            S_JRUN:
            begin
                x_raddr     = j_reg;
                acc_en_next = 1'b1;
                self_next   = (j_reg == i_reg);
                j_next      = j_reg + 1'b1;
                if (j_reg == I_LAST)
                begin
                    state_next = S_JEND;
                end
            end
            S_JEND:
            begin
                state_next = S_WGT;
            end
            S_WGT:
            begin
                cmd.latch_w = 1'b1;
                p_next      = '0;
                state_next  = S_PRUN;
            end
            // mix this slot's share bytes into the secret
            S_PRUN:
            begin
                mix_en_next  = 1'b1;
                mix_pos_next = p_reg;
                p_next       = p_reg + 1'b1;
                if (p_reg == P_LAST)
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                if (i_reg == I_LAST)
                begin
                    p_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_IREAD;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_last = (p_reg == P_LAST);
                    p_next        = p_reg + 1'b1;
                    if (p_reg == P_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            p_reg       <= '0;
            acc_en_reg  <= 1'b0;
            self_reg    <= 1'b0;
            mix_en_reg  <= 1'b0;
            mix_pos_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            p_reg       <= p_next;
            acc_en_reg  <= acc_en_next;
            self_reg    <= self_next;
            mix_en_reg  <= mix_en_next;
            mix_pos_reg <= mix_pos_next;
        end
    end

    assign s_raddr  = {i_reg, ssc_pkg::ROW_BITS'(p_reg)};
    assign mix_pos  = mix_pos_reg;
    assign emit_pos = p_reg;

endmodule

// ===== hdl/shamir_share_combine_top.sv =====
`timescale 1ns / 1ps
// Shamir share recombination over GF(256). A load item (tuser 0) with slot and position
// in range stores one share byte and the slot's x coordinate; an out-of-range load is
// accepted and dropped. An extract item (tuser 1) walks every slot: each present slot
// sums its Lagrange weight through the x table RAM read port, then mixes its share
// bytes from the share RAM; absent slots are skipped. The SHARE_BYTES secret items
// follow, one per cycle when not stalled, the last one with tlast, and the x table is
// then cleared. No item is taken while an extract runs.
`include "shamir_share_combine_top_defines.svh"
module shamir_share_combine_top #(
    parameter int SLOTS       = ssc_pkg::SLOTS_DEF,
    parameter int SHARE_BYTES = ssc_pkg::SHARE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot_index[7:0], x_coordinate[15:8], byte_position[20:16], share_data[28:21]
    input  logic [31:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // secret_byte[7:0], out_position[12:8]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = (SHARE_BYTES > 1) ? $clog2(SHARE_BYTES) : 1;

    ssc_pkg::ssc_cmd_t             cmd;
    ssc_pkg::ssc_sts_t             sts;
    logic [SW-1:0]                 x_raddr;
    logic [SW+ssc_pkg::ROW_BITS-1:0] s_raddr;
    logic [PW-1:0]                 mix_pos;
    logic [PW-1:0]                 emit_pos;
    logic [7:0]                    secret_byte;
    logic [4:0]                    out_position;

    ssc_ctrl #(.SLOTS(SLOTS), .SHARE_BYTES(SHARE_BYTES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_slot  (s_tdata[7:0]),
        .in_pos   (s_tdata[20:16]),
        .x_raddr  (x_raddr),
        .s_raddr  (s_raddr),
        .mix_pos  (mix_pos),
        .emit_pos (emit_pos),
        .cmd      (cmd),
        .sts      (sts)
    );

    ssc_datapath #(.SLOTS(SLOTS), .SHARE_BYTES(SHARE_BYTES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_slot      (s_tdata[7:0]),
        .in_x         (s_tdata[15:8]),
        .in_pos       (s_tdata[20:16]),
        .in_byte      (s_tdata[28:21]),
        .x_raddr      (x_raddr),
        .s_raddr      (s_raddr),
        .mix_pos      (mix_pos),
        .emit_pos     (emit_pos),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_byte     (secret_byte),
        .out_position (out_position),
        .out_last     (m_tlast)
    );

    assign m_tdata = {3'b000, out_position, secret_byte};

    // checks
    `SSC_ASSERT_SAME(a_last_pos, m_tvalid && m_tlast, out_position == 5'(SHARE_BYTES - 1))
    `SSC_ASSERT_SAME(a_pos_range, m_tvalid, {1'b0, out_position} < 6'(SHARE_BYTES))
    `SSC_ASSERT_NEXT(a_extract_busy, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule
